FILE: rtl/core/mmqe_pkg.sv
// Shared types, codes and constants for the market making quote engine.
// No dependencies; every other file of the block but mmqe_ram imports it.
package mmqe_pkg;

    localparam int HIST_DEPTH_DEF = 64;

    localparam logic [23:0] RISK_RST   = 24'd65536;
    localparam logic [23:0] SKEW_RST   = 24'd65536;
    localparam logic [31:0] HALF_RST   = 32'd0;
    localparam logic [15:0] QTY_RST    = 16'd1;
    localparam logic [6:0]  WLEN_RST   = 7'd20;

    localparam logic [31:0] ALPHA_GATE = 32'd32768;
    localparam logic [31:0] HALF_DEF   = 32'd32768;
    localparam logic [6:0]  LIMIT_MULT = 7'd100;
    localparam logic signed [45:0] PRICE_MAX = 46'sd549755813887;
    localparam logic signed [45:0] PRICE_MIN = -46'sd549755813888;

    // product width of |inventory| * k, and saturation point of the term
    localparam int A_W      = 56;
    localparam int CAP_BIT  = 57;
    localparam int TERM_W   = 42;

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISK = 3'd0,
        CFG_SKEW = 3'd1,
        CFG_HALF = 3'd2,
        CFG_QTY  = 3'd3,
        CFG_WLEN = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        midprice;
        logic [31:0]        book_spread;
        logic signed [31:0] alpha;
        logic signed [23:0] inventory;
        logic               high_vol_regime;
        logic [63:0]        event_time;
    } t_event;

    typedef struct packed {
        logic               buy_side;
        logic signed [39:0] quote_price;
        logic [15:0]        quote_quantity;
        logic [63:0]        order_time;
    } t_order;

    // status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_st;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_KA,
        ST_SUM,
        ST_DIV1,
        ST_DEV,
        ST_DIV2,
        ST_MSTART,
        ST_TERM,
        ST_RES,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/core/mmqe_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module mmqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/mmqe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mmqe_pkg for the unit status struct.
module mmqe_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output mmqe_pkg::t_unit_st    o_st,
    output logic [NUM_W-1:0]      o_quo
);
    import mmqe_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_q[NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : DEN_W'(w_sh);
        end
    end

    assign o_st  = '{busy: r_busy, done: r_done};
    assign o_quo = r_q;
endmodule

FILE: rtl/core/mmqe_smul.sv
// Bit-serial saturating multiplier: (a * b) >> 16, capped at 2^41.
// Depends on mmqe_pkg for widths and the unit status struct.
module mmqe_smul #(
    parameter int B_W = 56
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mmqe_pkg::A_W-1:0]       i_a,
    input  logic [B_W-1:0]                 i_b,
    output mmqe_pkg::t_unit_st             o_st,
    output logic [mmqe_pkg::TERM_W-1:0]    o_term
);
    import mmqe_pkg::*;

    localparam int CNT_W = $clog2(B_W + 1);

    logic               r_busy, r_done, r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [A_W-1:0]     r_a;
    logic [B_W-1:0]     r_b;
    logic [CAP_BIT-1:0] r_acc;
    logic [CAP_BIT+1:0] w_t;

    // msb first: acc = 2*acc + bit*a
    assign w_t = {1'b0, r_acc, 1'b0} + (r_b[B_W-1] ? (CAP_BIT+2)'(r_a) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_b <= {r_b[B_W-2:0], 1'b0};
            if (w_t[CAP_BIT+1:CAP_BIT] != 2'b00) begin
                r_sat <= 1'b1;
            end else begin
                r_acc <= w_t[CAP_BIT-1:0];
            end
        end
    end

    assign o_st   = '{busy: r_busy, done: r_done};
    assign o_term = r_sat ? (TERM_W'(1) << (TERM_W - 1))
                          : {1'b0, r_acc[CAP_BIT-1:16]};
endmodule

FILE: rtl/core/market_making_quote_engine_top.sv
// For an event that quotes, n = prices in the variance window (n >= 2), the time from request
// to order valid is set by the two serial passes over the window RAM port, two restoring
// divisions and the serial term multiply. With n < 2 the passes and divisions are skipped.
// One request at a time; the next one is accepted the cycle after the order loads, and a
// request that cannot quote frees the input via ST_PREP without an order. A finished order
// waits in ST_FIN and stalls the engine until the output register is empty or taken.
// Reset (synchronous, active low) clears control state and config; RAM is not cleared.
module market_making_quote_engine_top #(
    parameter int HISTORY_DEPTH = mmqe_pkg::HIST_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ev_valid,
    output logic                           o_ev_ready,
    input  mmqe_pkg::t_event               i_ev,
    output logic                           o_ord_valid,
    input  logic                           i_ord_ready,
    output mmqe_pkg::t_order               o_ord,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmqe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import mmqe_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int LW    = (CW > 7) ? CW : 7;
    localparam int SUM_W = 32 + CW;
    localparam int SQ_W  = 49 + CW;   // each squared term is at most 2^48

    // ---------------- configuration ----------------
    logic [23:0] r_risk, r_skew;
    logic [31:0] r_half;
    logic [15:0] r_qty;
    logic [6:0]  r_wlen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_risk <= RISK_RST;
            r_skew <= SKEW_RST;
            r_half <= HALF_RST;
            r_qty  <= QTY_RST;
            r_wlen <= WLEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RISK: r_risk <= i_cfg_data[23:0];
                CFG_SKEW: r_skew <= i_cfg_data[23:0];
                CFG_HALF: r_half <= i_cfg_data;
                CFG_QTY:  r_qty  <= i_cfg_data[15:0];
                CFG_WLEN: r_wlen <= i_cfg_data[6:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------- control ----------------
    t_state r_state, n_state;
    logic   ev_acc, rd_issue, div_start, mul_start, ord_load;
    logic   pass_drained, dev_drained;
    logic   r_rv, r_dv, r_ddv;
    logic   r_go, r_buy;
    logic [CW-1:0] r_n, r_iss;
    t_unit_st div_st, mul_st;

    assign ev_acc = i_ev_valid && o_ev_ready;

    // window pass complete: all reads issued and in-flight data consumed
    assign pass_drained = (r_iss == r_n) && !r_rv;
    assign dev_drained  = pass_drained && !r_dv && !r_ddv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (ev_acc) n_state = ST_PREP;
            ST_PREP:   n_state = r_go ? ST_KA : ST_IDLE;
            ST_KA:     n_state = (r_n < CW'(2)) ? ST_MSTART : ST_SUM;
            ST_SUM:    if (pass_drained) n_state = ST_DIV1;
            ST_DIV1:   if (div_st.done) n_state = ST_DEV;
            ST_DEV:    if (dev_drained) n_state = ST_DIV2;
            ST_DIV2:   if (div_st.done) n_state = ST_MSTART;
            ST_MSTART: n_state = ST_TERM;
            ST_TERM:   if (mul_st.done) n_state = ST_RES;
            ST_RES:    n_state = ST_FIN;
            ST_FIN:    if (ord_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ev_ready = (r_state == ST_IDLE);
        rd_issue   = ((r_state == ST_SUM) || (r_state == ST_DEV)) && (r_iss < r_n);
        div_start  = ((r_state == ST_SUM) && pass_drained) ||
                     ((r_state == ST_DEV) && dev_drained);
        mul_start  = (r_state == ST_MSTART);
        ord_load   = (r_state == ST_FIN) && (!o_ord_valid || i_ord_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- window store ----------------
    logic [AW-1:0] r_head, r_ptr, w_ptr0;
    logic [CW-1:0] r_count;
    logic [31:0]   w_rdata;
    logic          w_we;
    logic [LW-1:0] w_len;

    assign w_we   = ev_acc && (i_ev.midprice != 32'd0);
    assign w_ptr0 = (r_head == '0) ? AW'(HISTORY_DEPTH - 1) : r_head - 1'b1;
    assign w_len  = (LW'(r_wlen) > LW'(HISTORY_DEPTH)) ? LW'(HISTORY_DEPTH) : LW'(r_wlen);

    mmqe_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_head),
        .i_wdata (i_ev.midprice),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (w_we) begin
            r_head <= (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
            if (r_count < CW'(HISTORY_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // ---------------- arithmetic units ----------------
    logic [SQ_W-1:0]   w_div_num, w_quo;
    logic [CW-1:0]     w_div_den;
    logic [A_W-1:0]    r_a;
    logic [SQ_W-1:0]   r_var;
    logic [TERM_W-1:0] w_term, r_term;

    mmqe_div #(
        .NUM_W (SQ_W),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_st    (div_st),
        .o_quo   (w_quo)
    );

    mmqe_smul #(
        .B_W (SQ_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_a),
        .i_b     (r_var),
        .o_st    (mul_st),
        .o_term  (w_term)
    );

    // ---------------- datapath ----------------
    t_event          r_ev;
    logic [31:0]     r_k, r_mean, r_d;
    logic [63:0]     r_dd;
    logic [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0] r_sq;
    logic signed [45:0] r_rr;
    logic [22:0]     w_limit;
    logic signed [24:0] w_inv, w_lim_s;
    logic [23:0]     w_inv_abs;
    logic signed [45:0] w_price, w_clamp;

    // mean uses round half up: (sum + n/2) / n; variance divides by n-1
    assign w_div_num = (r_state == ST_SUM)
                     ? SQ_W'(r_sum) + SQ_W'(r_n >> 1) : r_sq;
    assign w_div_den = (r_state == ST_SUM) ? r_n : r_n - 1'b1;

    assign w_limit   = 23'(r_qty) * 23'(LIMIT_MULT);
    assign w_inv     = 25'($signed(i_ev.inventory));
    assign w_lim_s   = $signed({2'b00, w_limit});
    assign w_inv_abs = r_ev.inventory[23] ? 24'(-r_ev.inventory) : r_ev.inventory;

    logic [31:0] w_hsel;
    logic [32:0] w_spr1;
    assign w_spr1 = {1'b0, r_ev.book_spread} + 33'd1;
    always_comb begin
        w_hsel = (r_half != 32'd0) ? r_half : w_spr1[32:1];
        if (w_hsel == 32'd0) begin
            w_hsel = HALF_DEF;
        end
    end

    assign w_price = r_buy ? r_rr - $signed({14'd0, w_hsel})
                           : r_rr + $signed({14'd0, w_hsel});
    assign w_clamp = (w_price > PRICE_MAX) ? PRICE_MAX
                   : (w_price < PRICE_MIN) ? PRICE_MIN : w_price;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv  <= 1'b0;
            r_dv  <= 1'b0;
            r_ddv <= 1'b0;
        end else begin
            r_rv  <= rd_issue;
            r_dv  <= r_rv && (r_state == ST_DEV);
            r_ddv <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_acc) begin
            r_ev  <= i_ev;
            r_buy <= ($signed(i_ev.alpha) > $signed(ALPHA_GATE)) && (w_inv < w_lim_s);
            r_go  <= !i_ev.high_vol_regime &&
                     ((($signed(i_ev.alpha) > $signed(ALPHA_GATE)) && (w_inv < w_lim_s)) ||
                      (($signed(i_ev.alpha) < -$signed(ALPHA_GATE)) && (w_inv > -w_lim_s)));
        end
        if (r_state == ST_PREP) begin
            r_n   <= (r_count < CW'(w_len)) ? r_count : CW'(w_len);
            r_k   <= 32'((48'(r_risk) * 48'(r_skew)) >> 16);
            r_ptr <= w_ptr0;
            r_iss <= '0;
            r_sum <= '0;
            r_var <= '0;
        end
        if (r_state == ST_KA) begin
            r_a <= A_W'(w_inv_abs) * A_W'(r_k);
        end
        if (rd_issue) begin
            r_ptr <= (r_ptr == '0) ? AW'(HISTORY_DEPTH - 1) : r_ptr - 1'b1;
            r_iss <= r_iss + 1'b1;
        end
        if (r_rv && (r_state == ST_SUM)) begin
            r_sum <= r_sum + SUM_W'(w_rdata);
        end
        if ((r_state == ST_DIV1) && div_st.done) begin
            r_mean <= w_quo[31:0];
            r_ptr  <= w_ptr0;
            r_iss  <= '0;
            r_sq   <= '0;
        end
        // second pass: |p - mean|, square, round to Q.16, accumulate
        if (r_rv && (r_state == ST_DEV)) begin
            r_d <= (w_rdata >= r_mean) ? w_rdata - r_mean : r_mean - w_rdata;
        end
        if (r_dv) begin
            r_dd <= 64'(r_d) * 64'(r_d);
        end
        if (r_ddv) begin
            r_sq <= r_sq + SQ_W'((r_dd + 64'd32768) >> 16);
        end
        if ((r_state == ST_DIV2) && div_st.done) begin
            r_var <= w_quo;
        end
        if ((r_state == ST_TERM) && mul_st.done) begin
            r_term <= w_term;
        end
        if (r_state == ST_RES) begin
            r_rr <= $signed({14'd0, r_ev.midprice}) + 46'($signed(r_ev.alpha)) +
                    (r_ev.inventory[23] ? $signed({4'd0, r_term})
                                        : -$signed({4'd0, r_term}));
        end
    end

    // ---------------- output register ----------------
    logic   r_ovalid;
    t_order r_ord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ord_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ord_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ord_load) begin
            r_ord.buy_side       <= r_buy;
            r_ord.quote_price    <= w_clamp[39:0];
            r_ord.quote_quantity <= r_qty;
            r_ord.order_time     <= r_ev.event_time;
        end
    end

    assign o_ord_valid = r_ovalid;
    assign o_ord       = r_ord;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HISTORY_DEPTH))
        else $error("window count past depth");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_acc |=> (r_state == ST_PREP))
        else $error("accepted event did not start processing");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_st.busy)
        else $error("multiplier restarted while busy");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ord_valid && !i_ord_ready) |-> !ord_load)
        else $error("pending order overwritten");
endmodule
